/* rtl/necir_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_pkg: shared types and constants of the NEC IR pulse decoder
// Field widths, configuration register codes and reset values, decoder phase
// encoding and the classified word that moves from front end to back end.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Field widths
  localparam int unsigned WidthW  = 16;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CodeW   = 32;
  localparam int unsigned CntW    = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Queue between front end and back end
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // Bit count at which the mark that follows carries out the code
  localparam logic [CntW-1:0] CodeBits = CntW'(32);

  // Configuration register codes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_WINDOW = 3'd0,
    CFG_SPACE_WINDOW  = 3'd1,
    CFG_REPEAT_WINDOW = 3'd2,
    CFG_SHORT_WINDOW  = 3'd3,
    CFG_LONG_WINDOW   = 3'd4,
    CFG_END_GAP       = 3'd5,
    CFG_REPEAT_HOLD   = 3'd6
  } necir_cfg_idx_e;

  // Configuration reset values
  localparam logic [31:0]       HeaderWindowRst = 32'd655368000;
  localparam logic [31:0]       SpaceWindowRst  = 32'd327684000;
  localparam logic [31:0]       RepeatWindowRst = 32'd163842000;
  localparam logic [31:0]       ShortWindowRst  = 32'd45875600;
  localparam logic [31:0]       LongWindowRst   = 32'd124519800;
  localparam logic [WidthW-1:0] EndGapRst       = 16'd10000;
  localparam logic [TickW-1:0]  RepeatHoldRst   = 32'd150;

  // Decoder phase; reset starts straight in bit decoding
  typedef enum logic [2:0] {
    PH_BITS    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_SPACE   = 3'd2,
    PH_LAST    = 3'd3,
    PH_INVALID = 3'd4
  } necir_phase_e;

  // One width after window classification
  typedef struct packed {
    logic             start;
    logic             tmo;
    logic             gap_ok;    // width above end gap
    logic             hdr_ok;    // inside header window, inclusive
    logic             rpt_hit;   // inside repeat window, exclusive
    logic             spc_ok;    // inside space window, inclusive
    logic             short_lo;  // below short minimum
    logic             short_hi;  // above short maximum
    logic             long_one;  // at least long minimum
    logic             long_bad;  // above long maximum
    logic [TickW-1:0] now;
  } necir_cls_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } necir_qstat_t;

endpackage

/* rtl/necir_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_if: channel interfaces of the NEC IR pulse decoder
// Input width channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface necir_in_if import necir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WidthW-1:0] pulse_width;
  logic              start_frame;
  logic              timeout_seen;
  logic [TickW-1:0]  now_tick;

  modport source (output valid, pulse_width, start_frame, timeout_seen, now_tick,
                  input ready);
  modport sink   (input valid, pulse_width, start_frame, timeout_seen, now_tick,
                  output ready);
endinterface

interface necir_out_if import necir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code;
  logic             code_valid;
  logic             frame_done;

  modport source (output valid, code, code_valid, frame_done, input ready);
  modport sink   (input valid, code, code_valid, frame_done, output ready);
endinterface

interface necir_cfg_if import necir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/necir_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_front: input acceptance and window classification
// Holds the configuration registers, compares each incoming width against
// every window and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module necir_front import necir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  necir_in_if.sink         in_i,
  necir_cfg_if.sink        cfg_i,
  input  necir_qstat_t     qstat_i,
  output logic             push_o,
  output necir_cls_t       cls_o,
  output logic [TickW-1:0] hold_o
);

  logic [31:0]       hdr_win_q, spc_win_q, rpt_win_q, short_win_q, long_win_q;
  logic [WidthW-1:0] end_gap_q;
  logic [TickW-1:0]  hold_q;
  logic [WidthW-1:0] w;

  // Configuration writes, always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_win_q   <= HeaderWindowRst;
      spc_win_q   <= SpaceWindowRst;
      rpt_win_q   <= RepeatWindowRst;
      short_win_q <= ShortWindowRst;
      long_win_q  <= LongWindowRst;
      end_gap_q   <= EndGapRst;
      hold_q      <= RepeatHoldRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_HEADER_WINDOW: hdr_win_q   <= cfg_i.data;
        CFG_SPACE_WINDOW:  spc_win_q   <= cfg_i.data;
        CFG_REPEAT_WINDOW: rpt_win_q   <= cfg_i.data;
        CFG_SHORT_WINDOW:  short_win_q <= cfg_i.data;
        CFG_LONG_WINDOW:   long_win_q  <= cfg_i.data;
        CFG_END_GAP:       end_gap_q   <= cfg_i.data[WidthW-1:0];
        CFG_REPEAT_HOLD:   hold_q      <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign hold_o = hold_q;

  // Accept while the queue has room
  assign in_i.ready = !qstat_i.full;
  assign push_o     = in_i.valid && !qstat_i.full;

  // Classify the width against every window
  assign w = in_i.pulse_width;

  always_comb begin
    cls_o.start    = in_i.start_frame;
    cls_o.tmo      = in_i.timeout_seen;
    cls_o.gap_ok   = w > end_gap_q;
    cls_o.hdr_ok   = (w >= hdr_win_q[15:0]) && (w <= hdr_win_q[31:16]);
    cls_o.rpt_hit  = (w > rpt_win_q[15:0]) && (w < rpt_win_q[31:16]);
    cls_o.spc_ok   = (w >= spc_win_q[15:0]) && (w <= spc_win_q[31:16]);
    cls_o.short_lo = w < short_win_q[15:0];
    cls_o.short_hi = w > short_win_q[31:16];
    cls_o.long_one = w >= long_win_q[15:0];
    cls_o.long_bad = w > long_win_q[31:16];
    cls_o.now      = in_i.now_tick;
  end

endmodule

/* rtl/necir_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_queue: two-entry queue of classified words
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module necir_queue import necir_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  necir_cls_t   push_data_i,
  input  logic         pop_i,
  output necir_cls_t   pop_data_o,
  output necir_qstat_t qstat_o
);

  necir_cls_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign pop_data_o    = mem_q[rd_ptr_q];
  assign qstat_o.full  = cnt_q == QCntW'(QDepth);
  assign qstat_o.empty = cnt_q == '0;

endmodule

/* rtl/necir_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_back: frame decoding state machine and result register
// Takes one classified word per cycle while the result register is free or
// being drained, advances the frame phase, shifts in data bits, handles
// repeat frames and drives the result word.
module necir_back import necir_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  necir_qstat_t     qstat_i,
  input  necir_cls_t       cls_i,
  input  logic [TickW-1:0] hold_i,
  output logic             pop_o,
  necir_out_if.source      out_o
);

  necir_phase_e     phase_q, phase_d;
  logic             rep_q, rep_d;
  logic             exp_q, exp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CodeW-1:0] shift_q, shift_d;
  logic [CodeW-1:0] last_q, last_d;
  logic [TickW-1:0] stamp_q, stamp_d;
  logic [TickW-1:0] hold_end;
  logic             hold_ok;

  logic             res_valid;
  logic [CodeW-1:0] res_code;
  logic             res_done;

  logic             out_vld_q;
  logic [CodeW-1:0] code_q;
  logic             code_valid_q;
  logic             frame_done_q;

  // Pop when the result register is free or being drained
  assign pop_o = !qstat_i.empty && (!out_vld_q || out_o.ready);

  // Repeat hold window, wrapping sum
  assign hold_end = stamp_q + hold_i;
  assign hold_ok  = hold_end > cls_i.now;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      if (cls_i.start) begin
        phase_d = PH_HEADER;
      end else begin
        unique case (phase_q)
          PH_INVALID: phase_d = PH_INVALID;
          PH_LAST: begin
            if (!(cls_i.tmo || cls_i.gap_ok)) phase_d = PH_INVALID;
          end
          PH_HEADER: begin
            phase_d = cls_i.hdr_ok ? PH_SPACE : PH_INVALID;
          end
          PH_SPACE: begin
            phase_d = (cls_i.rpt_hit || cls_i.spc_ok) ? PH_BITS : PH_INVALID;
          end
          PH_BITS: begin
            if (cls_i.short_lo) begin
              phase_d = PH_INVALID;
            end else if (exp_q) begin
              if (cls_i.short_hi) begin
                phase_d = PH_INVALID;
              end else if (!(rep_q && hold_ok) && cnt_q == CodeBits) begin
                phase_d = PH_LAST;
              end
            end else if (cls_i.long_bad) begin
              phase_d = PH_INVALID;
            end
          end
          default: phase_d = PH_INVALID;
        endcase
      end
    end
  end

  // Datapath and result word
  always_comb begin
    rep_d     = rep_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    last_d    = last_q;
    stamp_d   = stamp_q;
    res_valid = 1'b0;
    res_code  = '0;
    res_done  = 1'b0;
    if (pop_o) begin
      if (cls_i.start) begin
        rep_d   = 1'b0;
        exp_d   = 1'b0;
        cnt_d   = '0;
        shift_d = '0;
      end else begin
        unique case (phase_q)
          PH_LAST: begin
            res_done = cls_i.tmo || cls_i.gap_ok;
          end
          PH_SPACE: begin
            if (cls_i.rpt_hit) begin
              rep_d = 1'b1;
              exp_d = 1'b1;
            end else if (cls_i.spc_ok) begin
              exp_d = 1'b1;
            end
          end
          PH_BITS: begin
            if (!cls_i.short_lo) begin
              if (exp_q) begin
                if (!cls_i.short_hi) begin
                  exp_d = 1'b0;
                  if (rep_q && hold_ok) begin
                    stamp_d   = cls_i.now;
                    res_code  = last_q;
                    res_valid = 1'b1;
                  end else if (cnt_q == CodeBits) begin
                    last_d    = shift_q;
                    stamp_d   = cls_i.now;
                    res_code  = shift_q;
                    res_valid = 1'b1;
                  end
                end
              end else begin
                exp_d = 1'b1;
                if (!cls_i.long_bad) begin
                  shift_d = {shift_q[CodeW-2:0], cls_i.long_one};
                  cnt_d   = cnt_q + CntW'(1);
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BITS;
      rep_q   <= 1'b0;
      exp_q   <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
      last_q  <= '0;
      stamp_q <= '0;
    end else begin
      phase_q <= phase_d;
      rep_q   <= rep_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      last_q  <= last_d;
      stamp_q <= stamp_d;
    end
  end

  // Result register: load on pop, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop_o) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q       <= res_code;
      code_valid_q <= res_valid;
      frame_done_q <= res_done;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.code       = code_q;
  assign out_o.code_valid = code_valid_q;
  assign out_o.frame_done = frame_done_q;

endmodule

/* rtl/nec_ir_pulse_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_core: NEC infrared frame decoder from measured widths
// Decodes header, repeat header and 32 data bits from mark/space widths and
// reports codes, repeated codes and frame completion.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one measured width word with start, timeout and tick.
//   out_o  returns exactly one result word per input word: code, code_valid
//          and frame_done, in input order.
//   cfg_i  writes the seven window/gap/hold registers by index; it is always
//          ready and must only be used while the decoder is idle.
// Timing:
//   A word accepted at one clock edge is classified and queued at that edge,
//   then popped from the queue and decoded into the result register, which
//   drives out_o. One word per cycle is sustained while out_o is ready; the
//   decode step in the back end sets that rate.
// Reset:
//   Registers return to their default windows; the decoder starts with no
//   header phase, the queue and the result register empty.
// Stall:
//   When out_o is not ready the result holds, the two-entry queue fills and
//   in_i.ready drops once it is full.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_core import necir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  necir_in_if.sink    in_i,
  necir_out_if.source out_o,
  necir_cfg_if.sink   cfg_i
);

  necir_qstat_t     qstat;
  necir_cls_t       push_cls, pop_cls;
  logic             push, pop;
  logic [TickW-1:0] hold;

  necir_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .qstat_i (qstat),
    .push_o  (push),
    .cls_o   (push_cls),
    .hold_o  (hold)
  );

  necir_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cls),
    .pop_i       (pop),
    .pop_data_o  (pop_cls),
    .qstat_o     (qstat)
  );

  necir_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .cls_i   (pop_cls),
    .hold_i  (hold),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* rtl/necir_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_chk: port-level checks of the NEC IR pulse decoder
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module necir_chk import necir_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CodeW-1:0] code_i,
  input logic             code_valid_i,
  input logic             frame_done_i
);

  // A word never reports a code and a frame end together
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(code_valid_i && frame_done_i))
    else $error("code and frame end in one word");

  // No code means a zero code field
  a_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !code_valid_i) |-> (code_i == '0))
    else $error("nonzero code without code_valid");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(code_i) && $stable(code_valid_i) && $stable(frame_done_i)))
    else $error("stalled result changed");

endmodule

bind nec_ir_pulse_decoder_core necir_chk u_necir_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .code_i       (out_o.code),
  .code_valid_i (out_o.code_valid),
  .frame_done_i (out_o.frame_done)
);

/* sim/necir_code_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// necir_code_checker: result checker for the NEC IR pulse decoder
// Watches the width, result and register channels. Decodes every accepted
// width word with its own copy of the decoder state and registers, and
// compares each result word, in order, with the oldest expected word.
// ----------------------------------------------------------------------------
module necir_code_checker import necir_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  necir_in_if  in_i,
  necir_out_if out_i,
  necir_cfg_if cfg_i,
  output int   err_cnt_o,
  output int   pend_cnt_o
);

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             code_valid;
    logic             frame_done;
  } code_word_t;

  // Register copies
  logic [31:0]       hdr_win, spc_win, rpt_win, shrt_win, long_win;
  logic [WidthW-1:0] gap_lim;
  logic [TickW-1:0]  hold_ticks;

  // Decoder copy
  logic             bad, at_gap, in_hdr, in_spc, in_rpt, want_mark;
  logic [CntW-1:0]  nbits;
  logic [CodeW-1:0] shreg, held_code;
  logic [TickW-1:0] stamp;

  code_word_t        codes_due[$];
  code_word_t        want, got, oldest;
  logic [WidthW-1:0] w;
  logic [TickW-1:0]  now, hold_end;
  int                errs;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_win    = HeaderWindowRst;
      spc_win    = SpaceWindowRst;
      rpt_win    = RepeatWindowRst;
      shrt_win   = ShortWindowRst;
      long_win   = LongWindowRst;
      gap_lim    = EndGapRst;
      hold_ticks = RepeatHoldRst;
      bad        = 1'b0;
      at_gap     = 1'b0;
      in_hdr     = 1'b0;
      in_spc     = 1'b0;
      in_rpt     = 1'b0;
      want_mark  = 1'b0;
      nbits      = '0;
      shreg      = '0;
      held_code  = '0;
      stamp      = '0;
      codes_due.delete();
      errs = 0;
      err_cnt_o  <= 0;
      pend_cnt_o <= 0;
    end else begin
      // Retire the oldest expected word on each result word
      if (out_i.valid && out_i.ready) begin
        got = {out_i.code, out_i.code_valid, out_i.frame_done};
        if (codes_due.size() == 0) begin
          if (errs < 10) begin
            $display("%0t: unexpected result word code %h valid %b done %b",
                     $time, got.code, got.code_valid, got.frame_done);
          end
          errs++;
        end else begin
          oldest = codes_due.pop_front();
          if (oldest.code != got.code || oldest.code_valid != got.code_valid ||
              oldest.frame_done != got.frame_done) begin
            if (errs < 10) begin
              $display("%0t: mismatch code exp %h got %h, valid exp %b got %b, done exp %b got %b",
                       $time, oldest.code, got.code, oldest.code_valid, got.code_valid,
                       oldest.frame_done, got.frame_done);
            end
            errs++;
          end
        end
      end

      // Track register writes
      if (cfg_i.valid && cfg_i.ready) begin
        case (necir_cfg_idx_e'(cfg_i.index))
          CFG_HEADER_WINDOW: hdr_win    = cfg_i.data;
          CFG_SPACE_WINDOW:  spc_win    = cfg_i.data;
          CFG_REPEAT_WINDOW: rpt_win    = cfg_i.data;
          CFG_SHORT_WINDOW:  shrt_win   = cfg_i.data;
          CFG_LONG_WINDOW:   long_win   = cfg_i.data;
          CFG_END_GAP:       gap_lim    = cfg_i.data[WidthW-1:0];
          CFG_REPEAT_HOLD:   hold_ticks = cfg_i.data;
          default: ;
        endcase
      end

      // Decode one width word and queue its result
      if (in_i.valid && in_i.ready) begin
        w    = in_i.pulse_width;
        now  = in_i.now_tick;
        want = '0;
        if (in_i.start_frame) begin
          bad       = 1'b0;
          at_gap    = 1'b0;
          in_spc    = 1'b0;
          in_rpt    = 1'b0;
          want_mark = 1'b0;
          in_hdr    = 1'b1;
          nbits     = '0;
          shreg     = '0;
        end else if (bad) begin
          // latched until the next start
        end else if (at_gap) begin
          if (in_i.timeout_seen || w > gap_lim) want.frame_done = 1'b1;
          else bad = 1'b1;
        end else if (in_hdr) begin
          if (w < hdr_win[15:0] || w > hdr_win[31:16]) begin
            bad = 1'b1;
          end else begin
            in_hdr = 1'b0;
            in_spc = 1'b1;
          end
        end else if (in_spc) begin
          if (w > rpt_win[15:0] && w < rpt_win[31:16]) begin
            in_spc    = 1'b0;
            in_rpt    = 1'b1;
            want_mark = 1'b1;
          end else if (w < spc_win[15:0] || w > spc_win[31:16]) begin
            bad = 1'b1;
          end else begin
            in_spc    = 1'b0;
            want_mark = 1'b1;
          end
        end else if (w < shrt_win[15:0]) begin
          bad = 1'b1;
        end else if (want_mark) begin
          if (w > shrt_win[31:16]) begin
            bad = 1'b1;
          end else begin
            want_mark = 1'b0;
            hold_end  = stamp + hold_ticks;
            if (in_rpt && hold_end > now) begin
              // repeat within the hold: send the last code again
              stamp           = now;
              want.code       = held_code;
              want.code_valid = 1'b1;
            end else if (nbits == CodeBits) begin
              held_code       = shreg;
              stamp           = now;
              at_gap          = 1'b1;
              want.code       = shreg;
              want.code_valid = 1'b1;
            end
          end
        end else begin
          want_mark = 1'b1;
          if (w > long_win[31:16]) begin
            bad = 1'b1;
          end else begin
            shreg = {shreg[CodeW-2:0], w >= long_win[15:0]};
            nbits = nbits + 1'b1;
          end
        end
        codes_due.push_back(want);
      end

      err_cnt_o  <= errs;
      pend_cnt_o <= codes_due.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top of the NEC IR pulse decoder
// Drives width words, register writes and result backpressure, and gives the
// verdict. Stimulus is a short directed part at reset windows, then phases
// of random frames (data, repeat, broken and noise) under several register
// settings, from realistic windows to all-zero and all-one extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import necir_pkg::*;

  localparam int CycleLimit = 200000;

  typedef enum int {
    SET_DEFAULT,
    SET_JITTER,
    SET_OPEN,
    SET_ZEROS,
    SET_ONES,
    SET_RAW
  } setting_e;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pend_cnt;
  int   cycle_cnt;

  necir_in_if  in_w();
  necir_out_if out_w();
  necir_cfg_if cfg_w();

  nec_ir_pulse_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w),
    .cfg_i  (cfg_w)
  );

  necir_code_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_w),
    .out_i      (out_w),
    .cfg_i      (cfg_w),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  // Register values as last written, used to shape widths
  logic [31:0] hdr_win, spc_win, rpt_win, shrt_win, long_win, gap_reg, hold_ticks;

  logic [31:0] tick;
  logic [31:0] mark_tick;
  int          words_sent;
  int          flaw_pos;
  int          tail_len;
  bit          calm;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result backpressure
  initial begin
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_w.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  function automatic logic [15:0] pick(input int lo, input int hi);
    if (lo >= 0 && lo <= hi) return 16'($urandom_range(hi, lo));
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] wild_width();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic rare_tmo();
    return $urandom_range(9) == 0;
  endfunction

  function automatic logic [15:0] mark_width();
    return pick(shrt_win[15:0], shrt_win[31:16]);
  endfunction

  // Bit space: one at or above the long minimum, zero below it
  function automatic logic [15:0] bit_space();
    int one_lo;
    int zero_hi;
    one_lo  = (long_win[15:0] > shrt_win[15:0]) ? long_win[15:0] : shrt_win[15:0];
    zero_hi = int'(long_win[15:0]) - 1;
    if (zero_hi > int'(long_win[31:16])) zero_hi = long_win[31:16];
    if ($urandom_range(1) || zero_hi < int'(shrt_win[15:0]))
      return pick(one_lo, long_win[31:16]);
    return pick(shrt_win[15:0], zero_hi);
  endfunction

  // Trailing gap: mostly long or timed out, sometimes too short
  function automatic void gap_pick(output logic [15:0] w, output logic tmo);
    int r;
    r = $urandom_range(9);
    if (gap_reg[15:0] == 16'hFFFF || r < 3) begin
      tmo = 1'b1;
      w   = 16'($urandom());
    end else if (r == 3) begin
      tmo = 1'b0;
      w   = pick(0, gap_reg[15:0]);
    end else begin
      tmo = 1'b0;
      w   = pick(int'(gap_reg[15:0]) + 1, 65535);
    end
  endfunction

  // Send one width word; idle first now and then
  task automatic send_word(input logic [15:0] w, input logic sf, input logic tmo);
    int gap;
    if (!calm && $urandom_range(99) < 3) begin
      gap = $urandom_range(3, 1);
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_w.valid        <= 1'b1;
    in_w.pulse_width  <= w;
    in_w.start_frame  <= sf;
    in_w.timeout_seen <= tmo;
    in_w.now_tick     <= tick;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    words_sent++;
    if ($urandom_range(49) == 0) tick = $urandom();
    else tick = tick + $urandom_range(6);
  endtask

  // Word inside a frame: corrupt the chosen one, stop shortly after it
  task automatic frame_word(input logic [15:0] w, input logic tmo, inout int pos,
                            output bit quit);
    if (pos == flaw_pos) w = wild_width();
    send_word(w, 1'b0, tmo);
    quit = flaw_pos >= 0 && pos >= flaw_pos + tail_len;
    pos++;
  endtask

  task automatic data_frame(input int nbits);
    int          pos;
    bit          quit;
    logic [15:0] w;
    logic        tmo;
    pos = 0;
    send_word(16'($urandom()), 1'b1, rare_tmo());
    frame_word(pick(hdr_win[15:0], hdr_win[31:16]), rare_tmo(), pos, quit);
    if (quit) return;
    frame_word(pick(spc_win[15:0], spc_win[31:16]), rare_tmo(), pos, quit);
    if (quit) return;
    frame_word(mark_width(), rare_tmo(), pos, quit);
    if (quit) return;
    for (int i = 0; i < nbits; i++) begin
      frame_word(bit_space(), rare_tmo(), pos, quit);
      if (quit) return;
      mark_tick = tick;
      frame_word(mark_width(), rare_tmo(), pos, quit);
      if (quit) return;
    end
    // trailing gap, then a few more that are checked as gaps again
    repeat ($urandom_range(3, 1)) begin
      gap_pick(w, tmo);
      frame_word(w, tmo, pos, quit);
      if (quit) return;
    end
  endtask

  task automatic repeat_frame();
    int  pos;
    bit  quit;
    int  rlo;
    int  rhi;
    pos = 0;
    rlo = int'(rpt_win[15:0]) + 1;
    rhi = int'(rpt_win[31:16]) - 1;
    send_word(16'($urandom()), 1'b1, rare_tmo());
    frame_word(pick(hdr_win[15:0], hdr_win[31:16]), rare_tmo(), pos, quit);
    if (quit) return;
    frame_word(pick(rlo, rhi), rare_tmo(), pos, quit);
    if (quit) return;
    for (int k = $urandom_range(2); k >= 0; k--) begin
      // land on either side of the hold limit now and then
      case ($urandom_range(3))
        0:       tick = mark_tick + hold_ticks - 1;
        1:       tick = mark_tick + hold_ticks;
        default: ;
      endcase
      mark_tick = tick;
      frame_word(mark_width(), rare_tmo(), pos, quit);
      if (quit || k == 0) return;
      frame_word(bit_space(), rare_tmo(), pos, quit);
      if (quit) return;
    end
  endtask

  task automatic noise_words(input int n);
    repeat (n) begin
      send_word($urandom_range(1) ? wild_width() : 16'($urandom()),
                $urandom_range(7) == 0, 1'($urandom_range(1)));
    end
  endtask

  task automatic random_run(input int budget);
    int goal;
    int r;
    int nbits;
    goal = words_sent + budget;
    while (words_sent < goal) begin
      flaw_pos = ($urandom_range(9) < 3) ? $urandom_range(70) : -1;
      tail_len = $urandom_range(2);
      r = $urandom_range(19);
      if (r < 12) begin
        r = $urandom_range(39);
        if (r == 0) nbits = 96;
        else if (r < 4) nbits = $urandom_range(40);
        else nbits = 32;
        data_frame(nbits);
      end else if (r < 17) begin
        repeat_frame();
      end else begin
        noise_words($urandom_range(6, 1));
      end
    end
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    in_w.valid <= 1'b0;
    do @(posedge clk_i); while (pend_cnt != 0);
  endtask

  task automatic put_reg(input necir_cfg_idx_e idx, input logic [31:0] val);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= val;
    @(posedge clk_i);
    while (!cfg_w.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(input setting_e kind);
    case (kind)
      SET_DEFAULT: begin
        hdr_win    = HeaderWindowRst;
        spc_win    = SpaceWindowRst;
        rpt_win    = RepeatWindowRst;
        shrt_win   = ShortWindowRst;
        long_win   = LongWindowRst;
        gap_reg    = 32'(EndGapRst);
        hold_ticks = RepeatHoldRst;
      end
      SET_JITTER: begin
        hdr_win    = {16'(10000 + $urandom_range(500)), 16'(8000 - $urandom_range(500))};
        spc_win    = {16'(5000 + $urandom_range(300)), 16'(4000 - $urandom_range(300))};
        rpt_win    = {16'(2500 + $urandom_range(200)), 16'(2000 - $urandom_range(200))};
        shrt_win   = {16'(700 + $urandom_range(100)), 16'(400 - $urandom_range(100))};
        long_win   = {16'(1900 + $urandom_range(300)), 16'(1400 - $urandom_range(200))};
        gap_reg    = $urandom_range(20000, 2000);
        hold_ticks = $urandom_range(600, 20);
      end
      SET_OPEN: begin
        hdr_win    = 32'hFFFF_0000;
        spc_win    = 32'hFFFF_0000;
        rpt_win    = 32'h0000_0000;
        shrt_win   = 32'hFFFF_0000;
        long_win   = 32'hFFFF_0000;
        gap_reg    = 32'h0000_0000;
        hold_ticks = 32'hFFFF_FFFF;
      end
      SET_ZEROS: begin
        hdr_win    = '0;
        spc_win    = '0;
        rpt_win    = '0;
        shrt_win   = '0;
        long_win   = '0;
        gap_reg    = '0;
        hold_ticks = '0;
      end
      SET_ONES: begin
        hdr_win    = '1;
        spc_win    = '1;
        rpt_win    = '1;
        shrt_win   = '1;
        long_win   = '1;
        gap_reg    = '1;
        hold_ticks = '1;
      end
      default: begin
        hdr_win    = $urandom();
        spc_win    = $urandom();
        rpt_win    = $urandom();
        shrt_win   = $urandom();
        long_win   = $urandom();
        gap_reg    = $urandom();
        hold_ticks = $urandom();
      end
    endcase
    put_reg(CFG_HEADER_WINDOW, hdr_win);
    put_reg(CFG_SPACE_WINDOW,  spc_win);
    put_reg(CFG_REPEAT_WINDOW, rpt_win);
    put_reg(CFG_SHORT_WINDOW,  shrt_win);
    put_reg(CFG_LONG_WINDOW,   long_win);
    put_reg(CFG_END_GAP,       gap_reg);
    put_reg(CFG_REPEAT_HOLD,   hold_ticks);
    cfg_w.valid <= 1'b0;
  endtask

  // Directed words at reset windows
  task automatic directed_run();
    // no start since reset: straight into bits, a one, a mark, then too short
    send_word(16'd1500, 1'b0, 1'b0);
    send_word(16'd400, 1'b0, 1'b0);
    send_word(16'd100, 1'b0, 1'b1);
    send_word(16'd600, 1'b0, 1'b0);
    // repeat frame within the hold: code of zero sent twice
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'd8000, 1'b0, 1'b0);
    send_word(16'd2001, 1'b0, 1'b0);
    send_word(16'd700, 1'b0, 1'b0);
    send_word(16'd1399, 1'b0, 1'b1);
    send_word(16'd500, 1'b0, 1'b0);
    // repeat window bound is exclusive and outside the space window
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd10000, 1'b0, 1'b0);
    send_word(16'd2500, 1'b0, 1'b0);
    // header mark just below its window
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd7999, 1'b0, 1'b0);
    // bit mark just above its window
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd9000, 1'b0, 1'b0);
    send_word(16'd4000, 1'b0, 1'b0);
    send_word(16'd701, 1'b0, 1'b0);
    // header mark just above its window
    send_word(16'd0, 1'b1, 1'b1);
    send_word(16'd10001, 1'b0, 1'b0);
    // bit mark below the short minimum
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd9000, 1'b0, 1'b0);
    send_word(16'd5000, 1'b0, 1'b0);
    send_word(16'd399, 1'b0, 1'b0);
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni             <= 1'b0;
    in_w.valid         <= 1'b0;
    in_w.pulse_width   <= '0;
    in_w.start_frame   <= 1'b0;
    in_w.timeout_seen  <= 1'b0;
    in_w.now_tick      <= '0;
    cfg_w.valid        <= 1'b0;
    cfg_w.index        <= CFG_HEADER_WINDOW;
    cfg_w.data         <= '0;
    tick       = '0;
    mark_tick  = '0;
    words_sent = 0;
    flaw_pos   = -1;
    tail_len   = 0;
    calm       = 1'b0;
    hdr_win    = HeaderWindowRst;
    spc_win    = SpaceWindowRst;
    rpt_win    = RepeatWindowRst;
    shrt_win   = ShortWindowRst;
    long_win   = LongWindowRst;
    gap_reg    = 32'(EndGapRst);
    hold_ticks = RepeatHoldRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_run();

    settle();
    apply_settings(SET_DEFAULT);
    random_run(200);
    settle();
    apply_settings(SET_JITTER);
    random_run(500);
    settle();
    apply_settings(SET_OPEN);
    random_run(250);
    settle();
    apply_settings(SET_ZEROS);
    random_run(150);
    settle();
    apply_settings(SET_ONES);
    random_run(150);
    settle();
    apply_settings(SET_RAW);
    random_run(100);
    // long stretch with no idling on either side
    settle();
    calm = 1'b1;
    apply_settings(SET_JITTER);
    random_run(400);

    settle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/necir_pkg.sv
rtl/necir_if.sv
rtl/necir_front.sv
rtl/necir_queue.sv
rtl/necir_back.sv
rtl/nec_ir_pulse_decoder_core.sv
rtl/necir_chk.sv
sim/necir_code_checker.sv
sim/tb_top.sv
